// ===== hdl/fgmt_round_robin_thread_scheduler_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Each macro expands to one labelled concurrent assertion that is disabled in reset.
`ifndef FGMT_ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define FGMT_ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FGMT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FGMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fgmt_pkg.sv =====
// Package for the round-robin thread scheduler: widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package fgmt_pkg;

    // Field and register widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COORD_W   = 12;
    localparam int TOTAL_W   = 25;
    localparam int POS_W     = 24;
    localparam int MISS_W    = 25;
    localparam int SLOT_W    = 26;
    localparam int THR_W     = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Reset values and limits
    localparam logic [CFG_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0]  HEIGHT_RESET = 13'd480;
    localparam logic [CFG_W-1:0]  DIM_MAX      = 13'd4096;
    localparam logic [MISS_W-1:0] MISS_MAX     = 25'd16777216;
    localparam logic [SLOT_W-1:0] SLOT_MAX     = 26'd33554432;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_STALL   = 2'd0,
        ACT_ISSUE   = 2'd1,
        ACT_IDLE    = 2'd2,
        ACT_RESTART = 2'd3
    } t_action;

    // Divider operand selection
    typedef enum logic [1:0] {
        DIV_TOTAL  = 2'd0,
        DIV_PER    = 2'd1,
        DIV_THREAD = 2'd2
    } t_div_sel;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_MUL,
        S_PER_GO,
        S_PER_WAIT,
        S_PERW_GO,
        S_PERW_WAIT,
        S_THR_GO,
        S_THR_WAIT,
        S_SLOT,
        S_NEXT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic     take;
        logic     geo_clamp;
        logic     geo_mul;
        logic     div_start;
        t_div_sel div_sel;
        logic     per_ld;
        logic     perw_ld;
        logic     thr_ld;
        logic     slot;
        logic     commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic dirty;
        logic div_done;
        logic sweep_last;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/fgmt_div.sv =====
// Restoring divider, one quotient bit per cycle, for the band geometry rebuild.
// Depends on fgmt_pkg for operand widths.
`default_nettype none

module fgmt_div
    import fgmt_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [TOTAL_W-1:0] i_dividend,
    input  wire logic [CFG_W-1:0]   i_divisor,
    output logic                    o_done,
    output logic [TOTAL_W-1:0]      o_quot,
    output logic [CFG_W-1:0]        o_rem
);

    localparam int CNT_W = $clog2(TOTAL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TOTAL_W - 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [TOTAL_W-1:0] r_quo;
    logic [CFG_W-1:0]   r_rem;
    logic [CFG_W-1:0]   r_dvs;

    logic [CFG_W:0]     trial;
    logic               fits;
    logic [CFG_W:0]     rem_next;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial    = {r_rem, r_quo[TOTAL_W-1]};
        fits     = trial >= {1'b0, r_dvs};
        rem_next = fits ? (trial - {1'b0, r_dvs}) : trial;
    end

    // Iterate from the start pulse over all TOTAL_W dividend bits, then flag done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[TOTAL_W-2:0], fits};
                r_rem <= rem_next[CFG_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

// ===== hdl/fgmt_dp.sv =====
// Scheduler datapath: configuration, band geometry, per-thread state, grant
// search and result registers. Depends on fgmt_pkg and fgmt_div.
`default_nettype none
`include "fgmt_round_robin_thread_scheduler_macros.svh"

module fgmt_dp
    import fgmt_pkg::*;
#(
    parameter int THREADS = 4
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_func,
    input  wire logic                 i_cache_miss,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    output logic [1:0]                o_action,
    output logic [THR_W-1:0]          o_served_thread,
    output logic [COORD_W-1:0]        o_pixel_x,
    output logic [COORD_W-1:0]        o_pixel_y,
    output logic                      o_band_finished,
    output logic                      o_frame_finished,
    output logic [THR_W-1:0]          o_next_thread,
    output logic [MISS_W-1:0]         o_thread_misses,
    output logic [SLOT_W-1:0]         o_thread_slots
);

    localparam int TW = $clog2(THREADS);
    localparam logic [TW-1:0] LAST_T = TW'(THREADS - 1);

    // First active thread at or after 'from', round-robin; top bit is found
    function automatic logic [TW:0] rr_find(input logic [TW-1:0]      from,
                                            input logic [THREADS-1:0] act);
        logic          found;
        logic [TW-1:0] idx;
        int            k;
        int            t;
        found = 1'b0;
        idx   = from;
        for (k = 0; k < THREADS; k++) begin
            t = int'(from) + k;
            if (t >= THREADS) begin
                t = t - THREADS;
            end
            if (!found && act[t]) begin
                found = 1'b1;
                idx   = TW'(t);
            end
        end
        return {found, idx};
    endfunction

    // Configuration and geometry
    logic [CFG_W-1:0]   r_cfg_w;
    logic [CFG_W-1:0]   r_cfg_h;
    logic               r_dirty;
    logic [CFG_W-1:0]   r_w_eff;
    logic [CFG_W-1:0]   r_h_eff;
    logic [TOTAL_W-1:0] r_total;
    logic [POS_W-1:0]   r_per;
    logic [POS_W-1:0]   r_len_last;
    logic [COORD_W-1:0] r_qp;
    logic [CFG_W-1:0]   r_rp;
    logic [TOTAL_W-1:0] r_acc_start;
    logic [CFG_W-1:0]   r_acc_x;
    logic [COORD_W-1:0] r_acc_y;
    logic [TW-1:0]      r_sw_t;

    // Per-thread state
    logic [POS_W-1:0]   r_pos  [THREADS];
    logic [COORD_W-1:0] r_x    [THREADS];
    logic [COORD_W-1:0] r_y    [THREADS];
    logic [COORD_W-1:0] r_sx   [THREADS];
    logic [COORD_W-1:0] r_sy   [THREADS];
    logic [MISS_W-1:0]  r_miss [THREADS];
    logic [SLOT_W-1:0]  r_slot [THREADS];
    logic [THREADS-1:0] r_pend;
    logic [THREADS-1:0] r_done;
    logic [THREADS-1:0] r_act;
    logic [TW-1:0]      r_cur;

    // Captured input word
    logic               r_func;
    logic               r_miss_in;

    // Result waiting for the grant step
    t_action            r_p_kind;
    logic [TW-1:0]      r_p_served;
    logic [COORD_W-1:0] r_p_x;
    logic [COORD_W-1:0] r_p_y;
    logic               r_p_bf;
    logic [MISS_W-1:0]  r_p_misses;
    logic [SLOT_W-1:0]  r_p_slots;

    // Output word
    t_action            r_o_action;
    logic [TW-1:0]      r_o_served;
    logic [COORD_W-1:0] r_o_x;
    logic [COORD_W-1:0] r_o_y;
    logic               r_o_bf;
    logic               r_o_frame;
    logic [TW-1:0]      r_o_next;
    logic [MISS_W-1:0]  r_o_misses;
    logic [SLOT_W-1:0]  r_o_slots;

    // Combinational helpers
    logic [CFG_W-1:0]     w_clamp;
    logic [CFG_W-1:0]     h_clamp;
    logic [2*CFG_W-1:0]   prod;
    logic [TOTAL_W-1:0]   div_dividend;
    logic [CFG_W-1:0]     div_divisor;
    logic                 div_done;
    logic [TOTAL_W-1:0]   div_quot;
    logic [CFG_W-1:0]     div_rem;
    logic [TOTAL_W-1:0]   last_len_full;
    logic [POS_W-1:0]     len_sweep;
    logic [CFG_W:0]       acc_x_sum;
    logic                 acc_x_wrap;
    logic [CFG_W-1:0]     acc_x_next;
    logic [COORD_W-1:0]   acc_y_next;
    logic [TW:0]          find_cur;
    logic                 cur_found;
    logic [TW-1:0]        s;
    logic [POS_W-1:0]     len_s;
    logic [POS_W:0]       pos_inc;
    logic                 band_end;
    logic                 is_stall;
    logic [SLOT_W-1:0]    slot_new;
    logic [MISS_W-1:0]    miss_new;
    logic [CFG_W-1:0]     x_inc;
    logic                 x_wrap;
    logic [TW-1:0]        next_from;
    logic [TW:0]          find_next;
    logic [TW-1:0]        next_out;

    // Clamp the frame dimensions to 1..4096
    always_comb begin
        if (r_cfg_w == '0) begin
            w_clamp = CFG_W'(1);
        end else if (r_cfg_w > DIM_MAX) begin
            w_clamp = DIM_MAX;
        end else begin
            w_clamp = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_clamp = CFG_W'(1);
        end else if (r_cfg_h > DIM_MAX) begin
            h_clamp = DIM_MAX;
        end else begin
            h_clamp = r_cfg_h;
        end
        prod = r_w_eff * r_h_eff;
    end

    // Select divider operands
    always_comb begin
        case (i_cmd.div_sel)
            DIV_TOTAL: begin
                div_dividend = r_total;
                div_divisor  = CFG_W'(THREADS);
            end
            DIV_PER: begin
                div_dividend = {1'b0, r_per};
                div_divisor  = r_w_eff;
            end
            DIV_THREAD: begin
                div_dividend = r_acc_start + {1'b0, r_pos[r_sw_t]};
                div_divisor  = r_w_eff;
            end
            default: begin
                div_dividend = r_total;
                div_divisor  = CFG_W'(THREADS);
            end
        endcase
    end

    fgmt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Sweep step: band length of the swept thread and next band start in x, y
    always_comb begin
        last_len_full = r_total - r_acc_start;
        len_sweep     = (r_sw_t == LAST_T) ? last_len_full[POS_W-1:0] : r_per;
        acc_x_sum     = {1'b0, r_acc_x} + {1'b0, r_rp};
        acc_x_wrap    = acc_x_sum >= {1'b0, r_w_eff};
        acc_x_next    = acc_x_wrap ? CFG_W'(acc_x_sum - {1'b0, r_w_eff})
                                   : acc_x_sum[CFG_W-1:0];
        acc_y_next    = r_acc_y + r_qp + COORD_W'(acc_x_wrap);
    end

    // Slot step: pick the served thread and work out its update
    always_comb begin
        find_cur  = rr_find(r_cur, r_act);
        cur_found = find_cur[TW];
        s         = find_cur[TW-1:0];
        len_s     = (s == LAST_T) ? r_len_last : r_per;
        pos_inc   = {1'b0, r_pos[s]} + 1'b1;
        band_end  = pos_inc >= {1'b0, len_s};
        is_stall  = !r_pend[s] && r_miss_in;
        slot_new  = (r_slot[s] < SLOT_MAX) ? (r_slot[s] + 1'b1) : r_slot[s];
        miss_new  = (r_miss[s] < MISS_MAX) ? (r_miss[s] + 1'b1) : r_miss[s];
        x_inc     = {1'b0, r_x[s]} + 1'b1;
        x_wrap    = x_inc == r_w_eff;
    end

    // Grant step: next active thread after the served one, searching from thread 0 after a restart
    always_comb begin
        if (r_p_kind == ACT_RESTART || r_p_served == LAST_T) begin
            next_from = '0;
        end else begin
            next_from = r_p_served + 1'b1;
        end
        find_next = rr_find(next_from, r_act);
        next_out  = find_next[TW] ? find_next[TW-1:0] : r_p_served;
    end

    // Configuration registers; any write marks the geometry stale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RESET;
            r_cfg_h <= HEIGHT_RESET;
            r_dirty <= 1'b1;
        end else begin
            if (i_cmd.geo_clamp) begin
                r_dirty <= 1'b0;
            end
            if (i_cfg_we) begin
                r_dirty <= 1'b1;
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:          r_cfg_w <= r_cfg_w;
                endcase
            end
        end
    end

    // Geometry: dimensions, pixel total, band size, band start walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw_t <= '0;
        end else begin
            if (i_cmd.geo_clamp) begin
                r_w_eff <= w_clamp;
                r_h_eff <= h_clamp;
            end
            if (i_cmd.geo_mul) begin
                r_total <= prod[TOTAL_W-1:0];
            end
            if (i_cmd.per_ld) begin
                r_per <= div_quot[POS_W-1:0];
            end
            if (i_cmd.perw_ld) begin
                r_qp        <= div_quot[COORD_W-1:0];
                r_rp        <= div_rem;
                r_acc_start <= '0;
                r_acc_x     <= '0;
                r_acc_y     <= '0;
                r_sw_t      <= '0;
            end
            if (i_cmd.thr_ld) begin
                r_acc_start <= r_acc_start + {1'b0, r_per};
                r_acc_x     <= acc_x_next;
                r_acc_y     <= acc_y_next;
                if (r_sw_t == LAST_T) begin
                    r_len_last <= len_sweep;
                end else begin
                    r_sw_t <= r_sw_t + 1'b1;
                end
            end
        end
    end

    // Capture the accepted input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func    <= i_func;
            r_miss_in <= i_cache_miss;
        end
    end

    // Per-thread state: sweep load, restart, slot update, grant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < THREADS; t++) begin
                r_pos[t]  <= '0;
                r_miss[t] <= '0;
                r_slot[t] <= '0;
            end
            r_pend <= '0;
            r_done <= '0;
            r_act  <= '0;
            r_cur  <= '0;
        end else if (i_cmd.thr_ld) begin
            r_x[r_sw_t]   <= div_rem[COORD_W-1:0];
            r_y[r_sw_t]   <= div_quot[COORD_W-1:0];
            r_sx[r_sw_t]  <= r_acc_x[COORD_W-1:0];
            r_sy[r_sw_t]  <= r_acc_y;
            r_act[r_sw_t] <= !r_done[r_sw_t] && (r_pos[r_sw_t] < len_sweep);
        end else if (i_cmd.slot && r_func) begin
            // Restart: every band back to its first pixel
            for (int t = 0; t < THREADS; t++) begin
                r_pos[t]  <= '0;
                r_miss[t] <= '0;
                r_slot[t] <= '0;
                r_x[t]    <= r_sx[t];
                r_y[t]    <= r_sy[t];
                r_act[t]  <= (r_per != '0) || (t == THREADS - 1);
            end
            r_pend <= '0;
            r_done <= '0;
            r_cur  <= '0;
        end else if (i_cmd.slot && cur_found) begin
            r_slot[s] <= slot_new;
            if (is_stall) begin
                r_pend[s] <= 1'b1;
                r_miss[s] <= miss_new;
            end else begin
                r_pend[s] <= 1'b0;
                r_pos[s]  <= pos_inc[POS_W-1:0];
                if (x_wrap) begin
                    r_x[s] <= '0;
                    r_y[s] <= r_y[s] + 1'b1;
                end else begin
                    r_x[s] <= x_inc[COORD_W-1:0];
                end
                if (band_end) begin
                    r_done[s] <= 1'b1;
                    r_act[s]  <= 1'b0;
                end
            end
        end else if (i_cmd.commit) begin
            r_cur <= next_out;
        end
    end

    // Hold the slot result until the grant step completes it
    always_ff @(posedge i_clk) begin
        if (i_cmd.slot) begin
            if (r_func) begin
                r_p_kind   <= ACT_RESTART;
                r_p_served <= '0;
                r_p_x      <= '0;
                r_p_y      <= '0;
                r_p_bf     <= 1'b0;
                r_p_misses <= '0;
                r_p_slots  <= '0;
            end else if (!cur_found) begin
                r_p_kind   <= ACT_IDLE;
                r_p_served <= r_cur;
                r_p_x      <= '0;
                r_p_y      <= '0;
                r_p_bf     <= 1'b0;
                r_p_misses <= '0;
                r_p_slots  <= '0;
            end else begin
                r_p_kind   <= is_stall ? ACT_STALL : ACT_ISSUE;
                r_p_served <= s;
                r_p_x      <= r_x[s];
                r_p_y      <= r_y[s];
                r_p_bf     <= !is_stall && band_end;
                r_p_misses <= is_stall ? miss_new : r_miss[s];
                r_p_slots  <= slot_new;
            end
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_action <= r_p_kind;
            r_o_served <= r_p_served;
            r_o_x      <= r_p_x;
            r_o_y      <= r_p_y;
            r_o_bf     <= r_p_bf;
            r_o_frame  <= !find_next[TW];
            r_o_next   <= next_out;
            r_o_misses <= r_p_misses;
            r_o_slots  <= r_p_slots;
        end
    end

    assign o_stat.dirty      = r_dirty;
    assign o_stat.div_done   = div_done;
    assign o_stat.sweep_last = r_sw_t == LAST_T;

    assign o_action         = r_o_action;
    assign o_served_thread  = THR_W'(r_o_served);
    assign o_pixel_x        = r_o_x;
    assign o_pixel_y        = r_o_y;
    assign o_band_finished  = r_o_bf;
    assign o_frame_finished = r_o_frame;
    assign o_next_thread    = THR_W'(r_o_next);
    assign o_thread_misses  = r_o_misses;
    assign o_thread_slots   = r_o_slots;

    // A finished band never competes for a slot
    for (genvar g = 0; g < THREADS; g++) begin : g_chk
        `FGMT_ASSERT_SAME(a_done_inactive, i_clk, i_rst_n, r_done[g], !r_act[g], "finished thread still active")
    end

    // The sweep pointer stays on a real thread
    `FGMT_ASSERT_SAME(a_sweep_range, i_clk, i_rst_n, 1'b1, r_sw_t <= LAST_T, "sweep pointer out of range")

    // The frame flag of a loaded word agrees with the active set
    `FGMT_ASSERT_NEXT(a_frame_flag, i_clk, i_rst_n, i_cmd.commit, r_o_frame == !(|r_act), "frame flag disagrees with active threads")

endmodule

`default_nettype wire

// ===== hdl/fgmt_ctrl.sv =====
// Scheduler controller: state machine sequencing geometry rebuild, slot update
// and result hand-off, plus the channel handshakes. Depends on fgmt_pkg.
`default_nettype none
`include "fgmt_round_robin_thread_scheduler_macros.svh"

module fgmt_ctrl
    import fgmt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    input  wire logic  i_out_stall,
    input  wire t_stat i_stat,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_take;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_stat.dirty) begin
                    n_state = S_CLAMP;
                end else if (i_in_valid) begin
                    n_state = S_SLOT;
                end
            end
            S_CLAMP:   n_state = S_MUL;
            S_MUL:     n_state = S_PER_GO;
            S_PER_GO:  n_state = S_PER_WAIT;
            S_PER_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_PERW_GO;
                end
            end
            S_PERW_GO: n_state = S_PERW_WAIT;
            S_PERW_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_THR_GO;
                end
            end
            S_THR_GO:  n_state = S_THR_WAIT;
            S_THR_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.sweep_last ? S_IDLE : S_THR_GO;
                end
            end
            S_SLOT:    n_state = S_NEXT;
            S_NEXT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Handshakes and datapath commands
    always_comb begin
        o_in_stall  = !(r_state == S_IDLE && !i_stat.dirty);
        in_take     = i_in_valid && !o_in_stall;
        o_cmd       = '0;
        o_cmd.take  = in_take;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_CLAMP: o_cmd.geo_clamp = 1'b1;
            S_MUL:   o_cmd.geo_mul   = 1'b1;
            S_PER_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_TOTAL;
            end
            S_PER_WAIT: o_cmd.per_ld = i_stat.div_done;
            S_PERW_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_PER;
            end
            S_PERW_WAIT: o_cmd.perw_ld = i_stat.div_done;
            S_THR_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_THREAD;
            end
            S_THR_WAIT: o_cmd.thr_ld = i_stat.div_done;
            S_SLOT:     o_cmd.slot   = 1'b1;
            S_NEXT: begin
                o_cmd.commit = out_free;
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: o_cmd.take = in_take;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A result only appears through the grant step
    `FGMT_ASSERT_SAME(a_rise_commit, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state == S_NEXT), "result appeared outside grant step")

    // An accepted word goes straight to the slot update
    `FGMT_ASSERT_NEXT(a_take_slot, i_clk, i_rst_n, in_take, r_state == S_SLOT, "accepted word not processed")

    // A blocked result keeps the next one waiting
    `FGMT_ASSERT_NEXT(a_hold_next, i_clk, i_rst_n, r_state == S_NEXT && r_out_valid && i_out_stall, r_state == S_NEXT && r_out_valid, "result overwritten while stalled")

endmodule

`default_nettype wire

// ===== hdl/fgmt_round_robin_thread_scheduler.sv =====
// Channel  Direction  Handshake                  Payload
// in       to block   i_in_valid / o_in_stall    i_func, i_cache_miss
// out      from block o_out_valid / i_out_stall  o_action .. o_thread_slots
// cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A word passes through accept, slot update, then grant and result load; the
// grant step waits while the output is stalled. After reset and after every
// configuration write the band geometry is rebuilt by the 25-step divider, with
// the input stalled: clamp, multiply, a division for the band size, one for its
// row split and one per thread. A stalled result holds in the output register
// while the next word is accepted and worked up to its grant step.
// Top level of the round-robin thread scheduler; depends on fgmt_pkg,
// fgmt_ctrl, fgmt_dp and fgmt_div.
`default_nettype none

module fgmt_round_robin_thread_scheduler
    import fgmt_pkg::*;
#(
    parameter int THREADS = 4
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_func,
    input  wire logic                 i_cache_miss,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_action,
    output logic [THR_W-1:0]          o_served_thread,
    output logic [COORD_W-1:0]        o_pixel_x,
    output logic [COORD_W-1:0]        o_pixel_y,
    output logic                      o_band_finished,
    output logic                      o_frame_finished,
    output logic [THR_W-1:0]          o_next_thread,
    output logic [MISS_W-1:0]         o_thread_misses,
    output logic [SLOT_W-1:0]         o_thread_slots,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;
    logic  cfg_we;

    // Registers take a word in any cycle
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    fgmt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    fgmt_dp #(
        .THREADS (THREADS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_cache_miss     (i_cache_miss),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_action         (o_action),
        .o_served_thread  (o_served_thread),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_band_finished  (o_band_finished),
        .o_frame_finished (o_frame_finished),
        .o_next_thread    (o_next_thread),
        .o_thread_misses  (o_thread_misses),
        .o_thread_slots   (o_thread_slots)
    );

endmodule

`default_nettype wire

// ===== bench/tb_fgmt_round_robin_thread_scheduler.sv =====
// Self-checking bench for the round-robin thread scheduler: drives slot and restart words,
// predicts every result word in-bench and compares field by field under random idling.
// Depends on fgmt_pkg and the fgmt_round_robin_thread_scheduler RTL.
`default_nettype none

module tb_fgmt_round_robin_thread_scheduler;
    import fgmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT          = 4;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_GAP  = 20;
    localparam int PRINT_CAP   = 40;

    // One word waiting to be sent; hold makes the sender wait for all results first
    typedef struct {
        logic func;
        logic miss;
        bit   hold;
    } slot_word_t;

    // One expected result word
    typedef struct {
        t_action           action;
        logic [THR_W-1:0]  served;
        logic [COORD_W-1:0] px;
        logic [COORD_W-1:0] py;
        logic              band_fin;
        logic              frame_fin;
        logic [THR_W-1:0]  nxt;
        logic [MISS_W-1:0] misses;
        logic [SLOT_W-1:0] slots;
    } slot_result_t;

    logic i_clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_func  = 1'b0;
    logic in_miss  = 1'b0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    logic                o_in_stall;
    logic                o_out_valid;
    logic [1:0]          o_action;
    logic [THR_W-1:0]    o_served_thread;
    logic [COORD_W-1:0]  o_pixel_x;
    logic [COORD_W-1:0]  o_pixel_y;
    logic                o_band_finished;
    logic                o_frame_finished;
    logic [THR_W-1:0]    o_next_thread;
    logic [MISS_W-1:0]   o_thread_misses;
    logic [SLOT_W-1:0]   o_thread_slots;
    logic                o_cfg_ready;

    fgmt_round_robin_thread_scheduler #(.THREADS(NT)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (in_func),
        .i_cache_miss     (in_miss),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (out_stall),
        .o_action         (o_action),
        .o_served_thread  (o_served_thread),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_band_finished  (o_band_finished),
        .o_frame_finished (o_frame_finished),
        .o_next_thread    (o_next_thread),
        .o_thread_misses  (o_thread_misses),
        .o_thread_slots   (o_thread_slots),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // Scheduler mirror: registers and per-thread frame state
    logic [CFG_W-1:0] img_width  = WIDTH_RESET;
    logic [CFG_W-1:0] img_height = HEIGHT_RESET;
    int unsigned turn;
    int unsigned band_pos [NT];
    bit          miss_pend[NT];
    bit          band_over[NT];
    int unsigned over_cnt;
    int unsigned miss_cnt [NT];
    int unsigned slot_cnt [NT];

    slot_word_t   slot_words[$];
    slot_result_t due_results[$];

    int  idle_pct  = 0;
    int  stall_pct = 0;
    bit  all_returned = 1'b1;
    int  quiet = 0;
    int  errors = 0;
    int  words_sent = 0;
    int  n_issue = 0, n_stall = 0, n_idle = 0, n_restart = 0, n_frames = 0;

    // Clamp a dimension register to its working range
    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > DIM_MAX) return 4096;
        return v;
    endfunction

    function automatic int unsigned frame_size();
        return clamp_dim(img_width) * clamp_dim(img_height);
    endfunction

    function automatic int unsigned band_base(int unsigned t);
        return t * (frame_size() / NT);
    endfunction

    // Last thread takes the remainder of the frame
    function automatic int unsigned band_size(int unsigned t);
        if (t == NT - 1) return frame_size() - band_base(t);
        return frame_size() / NT;
    endfunction

    function automatic bit thread_live(int unsigned t);
        return !band_over[t] && band_pos[t] < band_size(t);
    endfunction

    // First live thread from 'from' onward, round-robin; NT when none remain
    function automatic int unsigned first_live(int unsigned from);
        int unsigned t;
        for (int k = 0; k < NT; k++) begin
            t = (from + k) % NT;
            if (thread_live(t)) return t;
        end
        return NT;
    endfunction

    function automatic void restart_frame();
        turn = 0;
        over_cnt = 0;
        for (int t = 0; t < NT; t++) begin
            band_pos[t]  = 0;
            miss_pend[t] = 1'b0;
            band_over[t] = 1'b0;
            miss_cnt[t]  = 0;
            slot_cnt[t]  = 0;
        end
    endfunction

    // Work out the result of one word and advance the mirror
    function automatic slot_result_t schedule_slot(logic func, logic miss);
        slot_result_t r;
        int unsigned  s, nxt, pix, w;
        r.action    = ACT_IDLE;
        r.served    = '0;
        r.px        = '0;
        r.py        = '0;
        r.band_fin  = 1'b0;
        r.frame_fin = 1'b0;
        r.nxt       = '0;
        r.misses    = '0;
        r.slots     = '0;

        // Restart: fresh frame, miss bit ignored
        if (func) begin
            restart_frame();
            nxt = first_live(0);
            r.action    = ACT_RESTART;
            r.frame_fin = (nxt >= NT);
            r.nxt       = (nxt >= NT) ? '0 : THR_W'(nxt);
            return r;
        end

        turn = turn % NT;
        s = first_live(turn);
        // Nothing left in the frame: idle slot
        if (s >= NT) begin
            r.served    = THR_W'(turn);
            r.frame_fin = 1'b1;
            r.nxt       = THR_W'(turn);
            return r;
        end

        w   = clamp_dim(img_width);
        pix = band_base(s) + band_pos[s];
        r.px = COORD_W'(pix % w);
        r.py = COORD_W'(pix / w);
        if (slot_cnt[s] < SLOT_MAX) slot_cnt[s]++;

        // A first miss wastes the slot; the retry always issues
        if (!miss_pend[s] && miss) begin
            r.action = ACT_STALL;
            miss_pend[s] = 1'b1;
            if (miss_cnt[s] < MISS_MAX) miss_cnt[s]++;
        end else begin
            r.action = ACT_ISSUE;
            miss_pend[s] = 1'b0;
            band_pos[s]++;
            if (band_pos[s] >= band_size(s)) begin
                band_over[s] = 1'b1;
                if (over_cnt < NT) over_cnt++;
                r.band_fin = 1'b1;
            end
        end

        nxt = first_live((s + 1) % NT);
        if (nxt >= NT) begin
            r.frame_fin = 1'b1;
            nxt = s;
        end
        turn = nxt;

        r.served = THR_W'(s);
        r.nxt    = THR_W'(nxt);
        r.misses = MISS_W'(miss_cnt[s]);
        r.slots  = SLOT_W'(slot_cnt[s]);
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
        errors++;
        if (errors <= PRINT_CAP)
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    endtask

    task automatic check_field(string what, longint unsigned got, longint unsigned want);
        if (got !== want) flag_mismatch(what, got, want);
    endtask

    // Clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Driver: predict on acceptance, then present the next queued word
    always @(posedge i_clk) begin
        bit took;
        bit go;
        slot_word_t w;
        if (rst_n) begin
            took = in_valid && !o_in_stall;
            if (took) begin
                due_results.push_back(schedule_slot(in_func, in_miss));
                words_sent++;
            end
            if (!in_valid || took) begin
                go = slot_words.size() != 0 && $urandom_range(0, 99) >= idle_pct;
                if (go && slot_words[0].hold && (!all_returned || took)) go = 1'b0;
                if (go) begin
                    w = slot_words.pop_front();
                    in_func <= w.func;
                    in_miss <= w.miss;
                end
                in_valid <= go;
            end
        end
    end

    // Track whether every result has come back; settled at the falling edge
    always @(negedge i_clk) begin
        all_returned <= (due_results.size() == 0);
    end

    // Monitor: check each accepted result against the oldest expectation
    always @(posedge i_clk) begin
        slot_result_t want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (due_results.size() == 0) begin
                    flag_mismatch("result with nothing expected, action", o_action, 0);
                end else begin
                    want = due_results.pop_front();
                    check_field("action", o_action, want.action);
                    check_field("served_thread", o_served_thread, want.served);
                    check_field("pixel_x", o_pixel_x, want.px);
                    check_field("pixel_y", o_pixel_y, want.py);
                    check_field("band_finished", o_band_finished, want.band_fin);
                    check_field("frame_finished", o_frame_finished, want.frame_fin);
                    check_field("next_thread", o_next_thread, want.nxt);
                    check_field("thread_misses", o_thread_misses, want.misses);
                    check_field("thread_slots", o_thread_slots, want.slots);
                    case (want.action)
                        ACT_STALL: n_stall++;
                        ACT_ISSUE: begin
                            n_issue++;
                            if (want.frame_fin) n_frames++;
                        end
                        ACT_IDLE:  n_idle++;
                        default:   n_restart++;
                    endcase
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Watchdog: give up after a long stretch with no handshake on any channel
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles, %0d results outstanding",
                     quiet, due_results.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic queue_word(logic func, logic miss, bit hold);
        slot_word_t w;
        w.func = func;
        w.miss = miss;
        w.hold = hold;
        slot_words.push_back(w);
    endtask

    // Wait until nothing is queued, in flight or expected
    task automatic settle();
        @(negedge i_clk);
        while (slot_words.size() != 0 || in_valid || due_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) img_width = val;
        else img_height = val;
    endtask

    // Idling modes: none, sender gaps, receiver stalls, both
    task automatic set_idling(int mode);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 51; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 51; end
            default: begin idle_pct = 32; stall_pct = 32; end
        endcase
    endtask

    task automatic begin_phase(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, int mode);
        settle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        @(negedge i_clk);
        set_idling(mode);
    endtask

    // Stimulus
    initial begin
        int unsigned ph_w   [16] = '{3, 2, 8, 5, 1, 6, 4096, 1, 13, 7, 1, 4, 12, 2, 9, 5};
        int unsigned ph_h   [16] = '{3, 2, 8, 1, 2, 7, 1, 4096, 3, 2, 1, 4, 5, 3, 9, 5};
        bit          ph_rst [16] = '{1, 0, 1, 1, 1, 0, 1, 1, 1, 0, 1, 1, 0, 1, 1, 0};
        int          count;
        int          miss_pct;

        restart_frame();
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;

        // Reset geometry: slots with and without misses, a restart with miss set, then one more slot
        @(negedge i_clk);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b1, 1'b1, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);

        // Zero registers act as a 1x1 frame: empty bands, stale positions, idle slots
        begin_phase('0, '0, 0);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b1, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b1, 1'b0, 1'b1);
        queue_word(1'b0, 1'b0, 1'b0);

        // Oversized registers clamp to the largest frame
        begin_phase({CFG_W{1'b1}}, {CFG_W{1'b1}}, 0);
        queue_word(1'b1, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b0, 1'b0, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);
        queue_word(1'b0, 1'b1, 1'b0);

        // Random phases; some change geometry mid-frame without a restart
        for (int p = 0; p < 16; p++) begin
            begin_phase(CFG_W'(ph_w[p]), CFG_W'(ph_h[p]), p % 4);
            count    = (p == 6 || p == 7 || p == 10) ? 60 : 96;
            miss_pct = $urandom_range(15, 60);
            if (ph_rst[p]) queue_word(1'b1, 1'($urandom_range(0, 1)), 1'b0);
            for (int n = 0; n < count; n++)
                queue_word($urandom_range(0, 49) == 0, $urandom_range(0, 99) < miss_pct,
                           (n == 40) && (p % 3 == 0));
        end

        settle();
        repeat (SETTLE_GAP) @(posedge i_clk);

        $display("sent %0d words over 19 geometries: %0d issued, %0d stalled, %0d idle, %0d restarts",
                 words_sent, n_issue, n_stall, n_idle, n_restart);
        $display("%0d frames run to completion, %0d mismatches", n_frames, errors);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/fgmt_pkg.sv
hdl/fgmt_div.sv
hdl/fgmt_dp.sv
hdl/fgmt_ctrl.sv
hdl/fgmt_round_robin_thread_scheduler.sv
bench/tb_fgmt_round_robin_thread_scheduler.sv
